// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define ASSERT_CLKD(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked check that also runs through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/smpd_pkg.sv =====
package smpd_pkg;

    // protocol codes
    localparam int PROTO_BITS = 3;
    typedef logic [PROTO_BITS-1:0] proto_t;
    localparam proto_t PROTO_SERIAL7     = 3'd0;
    localparam proto_t PROTO_SYNC5       = 3'd1;
    localparam proto_t PROTO_SIGNMAG_A   = 3'd2;
    localparam proto_t PROTO_SIGNMAG_B   = 3'd3;
    localparam proto_t PROTO_BUS5        = 3'd4;
    localparam proto_t PROTO_SERIAL7_EXT = 3'd5;
    localparam proto_t PROTO_PS2         = 3'd6;
    localparam proto_t PROTO_TABLET      = 3'd7;

    // configuration register indexes
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = PROTO_BITS;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PROTOCOL = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHORD    = 1'b1;

    // input item kinds
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    // byte codes
    localparam logic [7:0] BAD_DATA = 8'h80;  // never valid as a data byte, except under PS/2
    localparam logic [7:0] EXT_MASK = 8'hDC;  // bits that must be clear in an extension byte

    // packet store
    localparam int PKT_MAX    = 5;
    localparam int COUNT_BITS = 3;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [PKT_MAX-1:0][7:0] pkt_view_t;

    // result widths
    localparam int DELTA_BITS = 10;
    localparam int POS_BITS   = 16;
    localparam int CELL_SHIFT = 3;
    localparam int CELL_BITS  = POS_BITS - CELL_SHIFT;
    localparam int CELL_ROUND = (1 << CELL_SHIFT) - 1;

    typedef logic signed [DELTA_BITS-1:0] delta_t;
    typedef logic signed [POS_BITS-1:0]   pos_t;
    typedef logic signed [CELL_BITS-1:0]  cell_t;

    // framing rules of one protocol
    typedef struct packed {
        logic [7:0] hdr_mask;
        logic [7:0] hdr_id;
        logic [7:0] data_mask;
        logic [7:0] data_id;
        count_t     len;
    } frame_fmt_t;

    // one decoded packet on its way to the accumulator
    typedef struct packed {
        logic       valid;
        logic [2:0] buttons;
        delta_t     dx;
        delta_t     dy;
    } motion_t;

    // result item, last field in the low bits
    typedef struct packed {
        logic [2:0] button_changes;
        logic       moved;
        cell_t      cell_y;
        cell_t      cell_x;
        pos_t       pos_y;
        pos_t       pos_x;
        delta_t     delta_y;
        delta_t     delta_x;
        logic [2:0] buttons;
    } result_t;

    localparam int RESULT_BITS = $bits(result_t);
    localparam int TDATA_BITS  = ((RESULT_BITS + 7) / 8) * 8;

    function automatic frame_fmt_t frame_fmt(input proto_t p);
        frame_fmt_t f;
        unique case (p) inside
            PROTO_SERIAL7, PROTO_SERIAL7_EXT: f = '{8'h40, 8'h40, 8'h40, 8'h00, 3'd3};
            PROTO_SYNC5, PROTO_BUS5:          f = '{8'hf8, 8'h80, 8'h00, 8'h00, 3'd5};
            PROTO_PS2:                        f = '{8'hc0, 8'h00, 8'h00, 8'h00, 3'd3};
            default:                          f = '{8'he0, 8'h80, 8'h80, 8'h00, 3'd3};
        endcase
        return f;
    endfunction

endpackage

// ===== rtl/smpd_decode.sv =====
module smpd_decode (
    input  smpd_pkg::proto_t    protocol,
    input  logic                chord_middle,
    input  smpd_pkg::pkt_view_t pkt,
    output logic [2:0]          buttons,
    output smpd_pkg::delta_t    dx,
    output smpd_pkg::delta_t    dy,
    output logic                hold
);
    import smpd_pkg::*;

    logic [7:0] b0, b1, b2, b3, b4;
    logic [2:0] code;
    delta_t     mag_x, mag_y;

    assign b0 = pkt[0];
    assign b1 = pkt[1];
    assign b2 = pkt[2];
    assign b3 = pkt[3];
    assign b4 = pkt[4];
    assign code  = b0[2:0];
    assign mag_x = {2'b00, b1};
    assign mag_y = {2'b00, b2};

    function automatic delta_t sext8(input logic [7:0] v);
        return {{(DELTA_BITS-8){v[7]}}, v};
    endfunction

    always_comb begin
        buttons = 3'b000;
        dx      = '0;
        dy      = '0;
        hold    = 1'b0;
        unique case (protocol) inside
            PROTO_SERIAL7, PROTO_SERIAL7_EXT: begin
                buttons = {b0[5], 1'b0, b0[4]};
                if (chord_middle && b0[5] && b0[4]) begin
                    buttons = 3'b010;
                end
                dx   = sext8({b0[1:0], b1[5:0]});
                dy   = sext8({b0[3:2], b2[5:0]});
                hold = !chord_middle;
            end
            PROTO_SYNC5: begin
                buttons = ~b0[2:0];
                dx      = sext8(b1) + sext8(b3);
                dy      = delta_t'(0) - (sext8(b2) + sext8(b4));
            end
            PROTO_BUS5: begin
                buttons = ~b0[2:0];
                dx      = sext8(b1);
                dy      = delta_t'(0) - sext8(b2);
            end
            PROTO_PS2: begin
                buttons = {b0[0], b0[2], b0[1]};
                dx      = {b0[4], b0[4], b1};
                dy      = delta_t'(0) - delta_t'({b0[5], b0[5], b2});
            end
            default: begin
                // sign/magnitude formats and the tablet
                if (protocol == PROTO_TABLET) begin
                    buttons = (code == 3'd1) ? 3'b001 :
                              (code == 3'd2) ? 3'b010 :
                              (code == 3'd3) ? 3'b100 : 3'b000;
                end else begin
                    buttons = code;
                end
                dx = b0[4] ? mag_x : delta_t'(0) - mag_x;
                dy = b0[3] ? delta_t'(0) - mag_y : mag_y;
            end
        endcase
    end

endmodule

// ===== rtl/smpd_frame.sv =====
module smpd_frame (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  logic              op,
    input  logic [7:0]        byte_in,
    input  smpd_pkg::proto_t  protocol,
    input  logic              chord_middle,
    output smpd_pkg::motion_t motion
);
    import smpd_pkg::*;

    logic [7:0] pkt_reg [PKT_MAX];
    count_t     count_reg, count_next;
    logic       held_valid_reg, held_valid_next;
    logic [2:0] held_btn_reg, held_btn_next;
    delta_t     held_dx_reg, held_dx_next;
    delta_t     held_dy_reg, held_dy_next;

    frame_fmt_t fmt;
    count_t     cnt, slot, cnt_inc, count_parse;
    logic       hdr_ok, store, done, pkt_we;
    pkt_view_t  view;
    logic [2:0] dec_btn;
    delta_t     dec_dx, dec_dy;
    logic       dec_hold;

    // framing of one received byte
    always_comb begin
        fmt = frame_fmt(protocol);
        cnt = count_reg;
        // a bad data byte drops the partial packet and is retried as a header (not under PS/2)
        if (cnt != '0 && protocol != PROTO_PS2 &&
            (((byte_in & fmt.data_mask) != fmt.data_id) || byte_in == BAD_DATA)) begin
            cnt = '0;
        end
        hdr_ok  = (byte_in & fmt.hdr_mask) == fmt.hdr_id;
        store   = (cnt != '0) || hdr_ok;
        slot    = (cnt >= count_t'(PKT_MAX)) ? count_t'(0) : cnt;
        cnt_inc = slot + count_t'(1);
        done    = store && (cnt_inc == fmt.len);
        if (!store || done) begin
            count_parse = '0;
        end else begin
            count_parse = cnt_inc;
        end
        for (int i = 0; i < PKT_MAX; i++) begin
            view[i] = (slot == count_t'(i)) ? byte_in : pkt_reg[i];
        end
    end

    smpd_decode u_decode (
        .protocol     (protocol),
        .chord_middle (chord_middle),
        .pkt          (view),
        .buttons      (dec_btn),
        .dx           (dec_dx),
        .dy           (dec_dy),
        .hold         (dec_hold)
    );

    always_comb begin
        motion          = '0;
        count_next      = count_reg;
        held_valid_next = held_valid_reg;
        held_btn_next   = held_btn_reg;
        held_dx_next    = held_dx_reg;
        held_dy_next    = held_dy_reg;
        pkt_we          = 1'b0;
        if (op == OP_TIMEOUT) begin
            if (held_valid_reg) begin
                held_valid_next = 1'b0;
                motion          = '{1'b1, held_btn_reg, held_dx_reg, held_dy_reg};
            end
        end else if (held_valid_reg) begin
            held_valid_next = 1'b0;
            motion          = '{1'b1, held_btn_reg, held_dx_reg, held_dy_reg};
            if ((byte_in & EXT_MASK) == '0) begin
                // extension byte carries the middle button
                motion.buttons = held_btn_reg | {1'b0, byte_in[5], 1'b0};
            end else begin
                // count is zero here, so this byte only starts a packet
                pkt_we     = store;
                count_next = count_parse;
            end
        end else begin
            pkt_we     = store;
            count_next = count_parse;
            if (done) begin
                if (dec_hold) begin
                    held_valid_next = 1'b1;
                    held_btn_next   = dec_btn;
                    held_dx_next    = dec_dx;
                    held_dy_next    = dec_dy;
                end else begin
                    motion = '{1'b1, dec_btn, dec_dx, dec_dy};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            held_valid_reg <= 1'b0;
            held_btn_reg   <= '0;
            held_dx_reg    <= '0;
            held_dy_reg    <= '0;
        end else if (fire) begin
            count_reg      <= count_next;
            held_valid_reg <= held_valid_next;
            held_btn_reg   <= held_btn_next;
            held_dx_reg    <= held_dx_next;
            held_dy_reg    <= held_dy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && pkt_we) begin
            pkt_reg[slot] <= byte_in;
        end
    end

endmodule

// ===== rtl/smpd_emit.sv =====
module smpd_emit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              fire,
    input  smpd_pkg::motion_t motion,
    input  logic              out_ready,
    output logic              out_valid,
    output smpd_pkg::result_t result
);
    import smpd_pkg::*;

    pos_t       acc_x_reg, acc_x_next;
    pos_t       acc_y_reg, acc_y_next;
    logic [2:0] last_btn_reg;
    logic       out_valid_reg;
    result_t    result_reg, result_next;
    logic [2:0] btn;
    pos_t       adj_x, adj_y;
    logic       load;

    assign load = fire && motion.valid;

    always_comb begin
        btn = motion.buttons;
        // left and right together read as middle
        if (btn[2] && btn[0]) begin
            btn = 3'b010;
        end
        acc_x_next = acc_x_reg + {{(POS_BITS-DELTA_BITS){motion.dx[DELTA_BITS-1]}}, motion.dx};
        acc_y_next = acc_y_reg + {{(POS_BITS-DELTA_BITS){motion.dy[DELTA_BITS-1]}}, motion.dy};
        // divide by 8 toward zero: bias negatives before the shift
        adj_x = acc_x_next + (acc_x_next[POS_BITS-1] ? pos_t'(CELL_ROUND) : pos_t'(0));
        adj_y = acc_y_next + (acc_y_next[POS_BITS-1] ? pos_t'(CELL_ROUND) : pos_t'(0));

        result_next.buttons        = btn;
        result_next.delta_x        = motion.dx;
        result_next.delta_y        = motion.dy;
        result_next.pos_x          = acc_x_next;
        result_next.pos_y          = acc_y_next;
        result_next.cell_x         = adj_x[POS_BITS-1:CELL_SHIFT];
        result_next.cell_y         = adj_y[POS_BITS-1:CELL_SHIFT];
        result_next.moved          = (motion.dx != '0) || (motion.dy != '0);
        result_next.button_changes = btn ^ last_btn_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            last_btn_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                acc_x_reg     <= acc_x_next;
                acc_y_reg     <= acc_y_next;
                last_btn_reg  <= btn;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ===== rtl/serial_mouse_packet_decoder.sv =====
// Serial mouse packet decoder.
// Input stream: one received mouse byte per item in s_axis_tdata; s_axis_tuser
// set marks a timeout item that flushes a packet held back for a possible
// middle-button extension byte. Output stream: one item per finished packet
// with buttons, motion, wrapping 16-bit position, position / 8 and change flags.
// cfg_wr_en/cfg_index/cfg_data write the protocol select (index 0) and the
// chord-middle enable (index 1); write them only while the block is idle.
// Path: an accepted item sits in the input register, is decoded and accumulated
// from there, and its result is captured in the output register.
// Throughput: one item per cycle while no result waits unread, set by the
// single decode/accumulate stage between the input and output registers.
// Stall: while a result waits with m_axis_tready low, the input register keeps
// the next item and takes another only once the result is gone or being taken.
// Reset (aresetn low, synchronous): empties both registers, clears the byte
// count, the held packet, the position and the button history, and selects
// protocol 0 without chord mode. Bytes of a half-built packet are not cleared.
module serial_mouse_packet_decoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // [7:0] byte_value
    input  logic                                s_axis_tuser,  // [0] operation
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [2:0] buttons, [12:3] delta_x, [22:13] delta_y, [38:23] pos_x,
    // [54:39] pos_y, [67:55] cell_x, [80:68] cell_y, [81] moved,
    // [84:82] button_changes, upper bits zero
    output logic [smpd_pkg::TDATA_BITS-1:0]     m_axis_tdata,
    // configuration writes
    input  logic                                cfg_wr_en,
    input  logic [smpd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [smpd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import smpd_pkg::*;

    // config registers
    proto_t     protocol_reg;
    logic       chord_reg;

    // input register
    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_byte_reg;

    logic       stall, fire, s_accept;
    motion_t    motion;
    result_t    result;

    // the stage only holds when a result sits unread at the output
    assign stall    = m_axis_tvalid && !m_axis_tready;
    assign fire     = in_valid_reg && !stall;
    assign s_axis_tready = !in_valid_reg || !stall;
    assign s_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            protocol_reg <= PROTO_SERIAL7;
            chord_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PROTOCOL: protocol_reg <= cfg_data;
                CFG_CHORD:    chord_reg    <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg   <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
    end

    // packet assembly, protocol decode and the held packet
    smpd_frame u_frame (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .op           (in_op_reg),
        .byte_in      (in_byte_reg),
        .protocol     (protocol_reg),
        .chord_middle (chord_reg),
        .motion       (motion)
    );

    // position accumulation and the output register
    smpd_emit u_emit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .motion    (motion),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .result    (result)
    );

    assign m_axis_tdata = {{(TDATA_BITS-RESULT_BITS){1'b0}}, result};

endmodule

// ===== rtl/smpd_checker.sv =====
`include "assert_macros.svh"

module smpd_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [smpd_pkg::TDATA_BITS-1:0] m_axis_tdata
);
    import smpd_pkg::*;

    result_t r;
    assign r = m_axis_tdata[RESULT_BITS-1:0];

    `ASSERT_CLKD(a_stall_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
    `ASSERT_CLKD(a_moved_flag, aclk, aresetn, m_axis_tvalid |-> (r.moved == ((r.delta_x != '0) || (r.delta_y != '0))), "moved flag disagrees with motion")
    `ASSERT_CLKD(a_no_outer_pair, aclk, aresetn, m_axis_tvalid |-> !(r.buttons[2] && r.buttons[0]), "left and right reported together")
    `ASSERT_CLKD(a_cell_pos, aclk, aresetn, m_axis_tvalid && !r.pos_x[POS_BITS-1] |-> r.cell_x == r.pos_x[POS_BITS-1:CELL_SHIFT], "cell_x does not match pos_x")
    `ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_axis_tvalid, "result valid right after reset")

endmodule

bind serial_mouse_packet_decoder smpd_checker u_smpd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/serial_mouse_packet_decoder_tb.sv =====
`timescale 1ns / 1ps

module serial_mouse_packet_decoder_tb;
    import smpd_pkg::*;

    // ------------------------------------------------------------------
    // Run parameters
    // ------------------------------------------------------------------
    localparam int CYCLE_LIMIT   = 600000;  // far above the slowest legal run
    localparam int SETTLE_CYCLES = 6;       // two-stage pipe plus margin
    localparam int PHASE_ITEMS   = 155;     // random items per register setting
    localparam int NUM_PHASES    = 12;

    // one input item: operation in tuser, byte in tdata
    typedef struct packed {
        logic       op;
        logic [7:0] value;
    } mouse_item_t;

    // ------------------------------------------------------------------
    // DUT signals, inputs driven to known values from time zero
    // ------------------------------------------------------------------
    logic                     aclk          = 1'b0;
    logic                     aresetn       = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [7:0]               s_axis_tdata  = '0;   // [7:0] byte_value
    logic                     s_axis_tuser  = 1'b0; // [0] operation
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    // [2:0] buttons, [12:3] delta_x, [22:13] delta_y, [38:23] pos_x,
    // [54:39] pos_y, [67:55] cell_x, [80:68] cell_y, [81] moved,
    // [84:82] button_changes
    logic [TDATA_BITS-1:0]    m_axis_tdata;
    logic                     cfg_wr_en     = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index     = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data      = '0;

    serial_mouse_packet_decoder uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Bookkeeping
    // ------------------------------------------------------------------
    mouse_item_t rx_backlog[$];     // items waiting for the driver
    result_t     due_reports[$];    // predicted packets, oldest first
    mouse_item_t next_item;
    int          items_queued    = 0;
    int          items_taken     = 0;
    int          reports_checked = 0;
    int          mismatches      = 0;
    int          settings_run    = 0;
    int          cycles          = 0;
    int          send_gap        = 0;
    int          stall_left      = 0;
    bit          in_fire         = 1'b0;  // input handshake at the last rising edge
    bit          calm            = 1'b0;  // no idling on either side

    // ------------------------------------------------------------------
    // Predictor state: own copy of the registers and the decoder state
    // ------------------------------------------------------------------
    proto_t      proto_sel    = PROTO_SERIAL7;
    logic        chord_on     = 1'b0;
    logic [7:0]  pkt_buf [PKT_MAX];
    int          pkt_fill     = 0;
    logic [15:0] acc_x        = '0;
    logic [15:0] acc_y        = '0;
    logic [2:0]  prev_buttons = '0;
    bit          held         = 1'b0;
    logic [2:0]  held_btn     = '0;
    int          held_dx      = 0;
    int          held_dy      = 0;

    // framing per protocol code: header mask/id, data mask/id, length
    frame_fmt_t frame_plan [8] = '{
        '{8'h40, 8'h40, 8'h40, 8'h00, 3'd3},   // 7-bit serial
        '{8'hf8, 8'h80, 8'h00, 8'h00, 3'd5},   // five-byte sync serial
        '{8'he0, 8'h80, 8'h80, 8'h00, 3'd3},   // sign/magnitude
        '{8'he0, 8'h80, 8'h80, 8'h00, 3'd3},   // sign/magnitude
        '{8'hf8, 8'h80, 8'h00, 8'h00, 3'd5},   // bus
        '{8'h40, 8'h40, 8'h40, 8'h00, 3'd3},   // 7-bit serial, extended
        '{8'hc0, 8'h00, 8'h00, 8'h00, 3'd3},   // PS/2
        '{8'he0, 8'h80, 8'h80, 8'h00, 3'd3}    // tablet
    };

    function automatic int sx8(input logic [7:0] v);
        return int'($signed(v));
    endfunction

    // Button emulation, position update and result formatting for one packet.
    task automatic post_motion(input logic [2:0] btn, input int dx, input int dy);
        result_t r;
        int      px;
        int      py;
        if (btn[2] && btn[0])
            btn = 3'b010;               // left+right reads as middle only
        acc_x = acc_x + dx[15:0];
        acc_y = acc_y + dy[15:0];
        px = $signed(acc_x);
        py = $signed(acc_y);
        r.buttons        = btn;
        r.delta_x        = dx[DELTA_BITS-1:0];
        r.delta_y        = dy[DELTA_BITS-1:0];
        r.pos_x          = acc_x;
        r.pos_y          = acc_y;
        r.cell_x         = CELL_BITS'(px / 8);   // truncates toward zero
        r.cell_y         = CELL_BITS'(py / 8);
        r.moved          = (dx != 0) || (dy != 0);
        r.button_changes = btn ^ prev_buttons;
        prev_buttons     = btn;
        due_reports.push_back(r);
    endtask

    // Packet assembly of one received byte; may finish, hold or drop a packet.
    task automatic take_byte(input logic [7:0] b);
        frame_fmt_t f;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [2:0] btn;
        logic [2:0] c;
        int         dx;
        int         dy;
        f = frame_plan[proto_sel];
        // resync: a bad data byte drops the partial packet (PS/2 never resyncs)
        if (pkt_fill != 0 && proto_sel != PROTO_PS2 &&
            ((b & f.data_mask) != f.data_id || b == BAD_DATA))
            pkt_fill = 0;
        if (pkt_fill == 0 && (b & f.hdr_mask) != f.hdr_id)
            return;                     // not a header, nothing in progress
        if (pkt_fill >= PKT_MAX)
            pkt_fill = 0;               // left over from a longer protocol
        pkt_buf[pkt_fill] = b;
        pkt_fill++;
        if (pkt_fill != int'(f.len))
            return;
        pkt_fill = 0;
        b0 = pkt_buf[0];
        b1 = pkt_buf[1];
        b2 = pkt_buf[2];
        case (proto_sel)
            PROTO_SERIAL7, PROTO_SERIAL7_EXT: begin
                btn = {b0[5], 1'b0, b0[4]};
                if (chord_on && b0[5:4] == 2'b11)
                    btn = 3'b010;
                dx = sx8({b0[1:0], b1[5:0]});
                dy = sx8({b0[3:2], b2[5:0]});
                if (!chord_on) begin
                    // wait for a possible middle-button extension byte
                    held     = 1'b1;
                    held_btn = btn;
                    held_dx  = dx;
                    held_dy  = dy;
                    return;
                end
            end
            PROTO_SYNC5: begin
                btn = ~b0[2:0];
                dx  = sx8(b1) + sx8(pkt_buf[3]);
                dy  = -(sx8(b2) + sx8(pkt_buf[4]));
            end
            PROTO_BUS5: begin
                btn = ~b0[2:0];
                dx  = sx8(b1);
                dy  = -sx8(b2);
            end
            PROTO_PS2: begin
                btn = {b0[0], b0[2], b0[1]};
                dx  = b0[4] ? int'(b1) - 256 : int'(b1);
                dy  = b0[5] ? 256 - int'(b2) : -int'(b2);
            end
            default: begin
                c = b0[2:0];
                if (proto_sel == PROTO_TABLET)  // one-hot code, 4..7 give nothing
                    btn = (c != 3'd0) ? 3'(32'd1 << (c - 3'd1)) : 3'b000;
                else
                    btn = c;
                dx = b0[4] ? int'(b1) : -int'(b1);
                dy = b0[3] ? -int'(b2) : int'(b2);
            end
        endcase
        post_motion(btn, dx, dy);
    endtask

    // Expected results of one accepted item.
    task automatic predict_mouse_report(input logic op, input logic [7:0] b);
        if (op == OP_TIMEOUT) begin
            if (held) begin
                held = 1'b0;
                post_motion(held_btn, held_dx, held_dy);
            end
            return;
        end
        if (held) begin
            held = 1'b0;
            if ((b & EXT_MASK) == 8'h00) begin
                // extension byte: bit 5 adds middle, byte consumed
                post_motion(held_btn | {1'b0, b[5], 1'b0}, held_dx, held_dy);
                return;
            end
            post_motion(held_btn, held_dx, held_dy);
        end
        take_byte(b);
    endtask

    // ------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch #%0d: %s", $time, mismatches, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %h want %h",
                                      reports_checked, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Idle lengths: mostly none, some short, a few long; none in calm phases
    // ------------------------------------------------------------------
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued items, changes inputs on the falling edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (in_fire || !s_axis_tvalid) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (rx_backlog.size() > 0) begin
                next_item = rx_backlog.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_item.value;
                s_axis_tuser  <= next_item.op;
                send_gap = gap_len();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result side back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left = gap_len();
        end
    end

    // ------------------------------------------------------------------
    // Monitor: handshakes sampled on the rising edge. Results are checked
    // before the item of the same edge is predicted, so a stray result
    // cannot be paired with a brand-new expectation.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[RESULT_BITS-1:0];
                if (due_reports.size() == 0) begin
                    report_mismatch("result arrived with nothing expected");
                end else begin
                    want = due_reports.pop_front();
                    check_field("buttons",        got.buttons,        want.buttons);
                    check_field("delta_x",        got.delta_x,        want.delta_x);
                    check_field("delta_y",        got.delta_y,        want.delta_y);
                    check_field("pos_x",          got.pos_x,          want.pos_x);
                    check_field("pos_y",          got.pos_y,          want.pos_y);
                    check_field("cell_x",         got.cell_x,         want.cell_x);
                    check_field("cell_y",         got.cell_y,         want.cell_y);
                    check_field("moved",          got.moved,          want.moved);
                    check_field("button_changes", got.button_changes, want.button_changes);
                end
                reports_checked++;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                items_taken++;
                predict_mouse_report(s_axis_tuser, s_axis_tdata);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d of %0d items taken",
                     cycles, items_taken, items_queued);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_item(input logic op, input logic [7:0] value);
        rx_backlog.push_back({op, value});
        items_queued++;
    endtask

    // Register write at an idle point; the predictor follows once the write is done.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_PROTOCOL)
            proto_sel = proto_t'(value);
        else
            chord_on = value[0];
    endtask

    // Wait until every item is taken and every result has come, then let
    // the pipe run empty for items that made no result.
    task automatic settle();
        do
            @(negedge aclk);
        while (items_taken != items_queued || due_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // One framed packet with random content; sometimes cut short.
    task automatic queue_packet(input proto_t p);
        frame_fmt_t f;
        int         n;
        logic [7:0] v;
        f = frame_plan[p];
        n = int'(f.len);
        if ($urandom_range(0, 9) == 0)
            n = $urandom_range(1, int'(f.len) - 1);
        for (int k = 0; k < n; k++) begin
            if (k == 0) begin
                v = (8'($urandom) & ~f.hdr_mask) | f.hdr_id;
            end else begin
                v = (8'($urandom) & ~f.data_mask) | f.data_id;
                if (p != PROTO_PS2 && v == BAD_DATA)
                    v = 8'h81;
            end
            add_item(OP_BYTE, v);
        end
    endtask

    // Mostly good packets; noise bytes, timeouts and extension-style bytes mixed in.
    task automatic queue_random_phase(input int count);
        int stop_at;
        int r;
        stop_at = items_queued + count;
        while (items_queued < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 76)
                queue_packet(proto_sel);
            else if (r < 86)
                add_item(OP_BYTE, 8'($urandom));
            else if (r < 93)
                add_item(OP_TIMEOUT, 8'($urandom));
            else
                add_item(OP_BYTE, 8'($urandom) & 8'h23);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        proto_t plan_proto [NUM_PHASES];
        logic   plan_chord [NUM_PHASES];
        mouse_item_t opening [19];

        // protocols in turn, chord mode on for the 7-bit formats and the
        // top code, ending back at the reset setting
        plan_proto = '{PROTO_SYNC5, PROTO_SIGNMAG_A, PROTO_SIGNMAG_B, PROTO_BUS5,
                       PROTO_SERIAL7_EXT, PROTO_PS2, PROTO_TABLET, PROTO_SERIAL7,
                       PROTO_SERIAL7, PROTO_SERIAL7_EXT, PROTO_TABLET,
                       PROTO_SERIAL7};
        plan_chord = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                       1'b1, 1'b1, 1'b1, 1'b0};

        // 7-bit serial, no chord mode
        opening = '{
            {OP_TIMEOUT, 8'hFF},                      // timeout, nothing held
            {OP_BYTE, 8'h00},                         // not a header: ignored
            {OP_BYTE, 8'h7F}, {OP_BYTE, 8'h3F},       // both buttons, max bits
            {OP_BYTE, 8'h3F},                         //   -> packet held
            {OP_BYTE, 8'h23},                         // extension byte merges middle
            {OP_BYTE, 8'h40}, {OP_BYTE, 8'h00},
            {OP_BYTE, 8'h00},                         // zero motion, held
            {OP_TIMEOUT, 8'h00},                      // timeout flushes it
            {OP_BYTE, 8'h4C}, {OP_BYTE, 8'h80},       // 0x80 as data drops packet
            {OP_BYTE, 8'h43}, {OP_BYTE, 8'h01},
            {OP_BYTE, 8'h3F},                         // held again
            {OP_BYTE, 8'hFF},                         // not an extension: emit + reparse
            {OP_BYTE, 8'h7F},                         // header bit in data: resync
            {OP_BYTE, 8'h20}, {OP_BYTE, 8'h1F}        // finish, left held into next phase
        };

        // synchronous reset, held low from time zero before release
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part at the lowest setting
        write_reg(CFG_PROTOCOL, PROTO_SERIAL7);
        write_reg(CFG_CHORD, '0);
        foreach (opening[i])
            add_item(opening[i].op, opening[i].value);
        settle();
        settings_run++;

        // random phases, one phase in four without idling
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_reg(CFG_PROTOCOL, plan_proto[ph]);
            write_reg(CFG_CHORD, CFG_DATA_BITS'(plan_chord[ph]));
            calm = (ph % 4 == 2);
            queue_random_phase(PHASE_ITEMS);
            settle();
            settings_run++;
        end

        $display("covered %0d register settings (all protocols, chord on and off)",
                 settings_run);
        $display("%0d items driven, %0d packet results checked, %0d mismatches",
                 items_taken, reports_checked, mismatches);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
